>>> hdl/fbpa_pkg.sv
// Shared types, register map and reset defaults for the fixed block pool allocator.
// Used by fixed_block_pool_allocator; has no dependencies of its own.
`timescale 1ns / 1ps

package fbpa_pkg;

   // Default size of the link memory (block slots).
   localparam int DEFAULT_MAX_BLOCKS = 256;

   // Field and register widths.
   localparam int COUNT_W  = 9;
   localparam int BYTES_W  = 16;
   localparam int PAD_W    = 13;
   localparam int STRIDE_W = 17;
   localparam int INDEX_W  = 8;
   localparam int OFFSET_W = 25;
   localparam int USED_W   = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [COUNT_W-1:0] RESET_COUNT = 9'd256;
   localparam logic [BYTES_W-1:0] RESET_BYTES = 16'd64;
   localparam logic [PAD_W-1:0]   RESET_PAD   = 13'd8;

   localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

   typedef enum logic [1:0] {
      REQ_ALLOC    = 2'd0,
      REQ_FREE     = 2'd1,
      REQ_FREE_ALL = 2'd2,
      REQ_RESIZE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_RESIZE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_BLOCK_COUNT = 2'd0,
      REG_BLOCK_BYTES = 2'd1,
      REG_BLOCK_PAD   = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_BUILD
   } state_type;

endpackage

>>> hdl/fixed_block_pool_allocator.sv
// Fixed block pool allocator: free list of block indices held in a link memory.
// An alloc that pops a block reads the successor link from the link memory, with
// busy high in ST_POP; free, resize and refused allocs answer at accept.
// Free-all and reset rebuild the chain at one link memory write per block, for the
// configured block count (clamped to 1..MAX_BLOCKS), busy held high meanwhile.
// Results are registered and shown on a one-cycle strobe; no stall.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [fbpa_pkg::INDEX_W-1:0]      req_freed_block,
   input  logic                              req_free_is_null,
   input  logic [fbpa_pkg::BYTES_W-1:0]      req_bytes,
   input  logic [fbpa_pkg::PAD_W-1:0]        req_align,
   // Response channel.
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [fbpa_pkg::INDEX_W-1:0]      rsp_block_index,
   output logic [fbpa_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic [fbpa_pkg::USED_W-1:0]       rsp_used_bytes,
   // Register port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fbpa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   // A block index needs IDX_W bits; a link also has to hold the end-of-list
   // code, which is MAX_BLOCKS itself, so it is LINK_W bits wide.
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W = IDX_W + fbpa_pkg::STRIDE_W;
   localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_BLOCKS);
   // Number of blocks chained by the build that follows reset.
   localparam int RESET_N = (int'(fbpa_pkg::RESET_COUNT) > MAX_BLOCKS) ?
                            MAX_BLOCKS : int'(fbpa_pkg::RESET_COUNT);

   // Control state.
   fbpa_pkg::state_type state_ff, state_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [fbpa_pkg::USED_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0]    build_cnt_ff, build_cnt_in;
   logic [LINK_W-1:0]   build_n_ff, build_n_in;
   logic                build_rsp_ff, build_rsp_in;

   // Configuration registers. The stride (block size plus pad) is kept as a
   // register of its own so that the offset path is a single multiply.
   logic [fbpa_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [fbpa_pkg::BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [fbpa_pkg::PAD_W-1:0]    pad_ff, pad_in;
   logic [fbpa_pkg::STRIDE_W-1:0] stride_ff, stride_in;

   // Response registers.
   logic                           rsp_strobe_ff, rsp_strobe_in;
   fbpa_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [fbpa_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [fbpa_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [fbpa_pkg::USED_W-1:0]    rsp_used_ff, rsp_used_in;

   // Link memory ports.
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [LINK_W-1:0] mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   logic [LINK_W-1:0] mem_rdata;

   // Helper terms.
   logic                           accept;
   logic                           csr_write;
   fbpa_pkg::reg_index_type        csr_index;
   logic [LINK_W-1:0]              count_clamped;
   logic                           build_last;
   logic [PROD_W-1:0]              offset_product;
   logic [fbpa_pkg::USED_W:0]      used_sum;
   logic                           freed_in_range;

   fbpa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign accept    = start && (state_ff == fbpa_pkg::ST_IDLE);
   assign csr_write = psel && penable && pwrite;
   assign csr_index = fbpa_pkg::reg_index_type'(paddr[3:2]);

   // A block count of zero still gives one block; counts above the memory
   // size are cut to the memory size.
   always_comb begin
      if (count_ff == '0) begin
         count_clamped = LINK_W'(1);
      end else if (int'(count_ff) > MAX_BLOCKS) begin
         count_clamped = LIST_END;
      end else begin
         count_clamped = LINK_W'(count_ff);
      end
   end

   assign build_last     = (LINK_W'(build_cnt_ff) == (build_n_ff - LINK_W'(1)));
   // During the pop cycle head_ff still holds the index that is being handed out.
   assign offset_product = PROD_W'(IDX_W'(head_ff)) * PROD_W'(stride_ff);
   assign used_sum       = {1'b0, used_ff} + (fbpa_pkg::USED_W + 1)'(bytes_ff);
   assign freed_in_range = (int'(req_freed_block) < MAX_BLOCKS);

   // Main sequencer: decodes the transaction, drives the link memory and
   // prepares the response registers.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      build_cnt_in  = build_cnt_ff;
      build_n_in    = build_n_ff;
      build_rsp_in  = build_rsp_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = fbpa_pkg::STATUS_OK;
      rsp_index_in  = '0;
      rsp_offset_in = '0;
      rsp_used_in   = used_ff;

      mem_we    = 1'b0;
      mem_waddr = IDX_W'(req_freed_block);
      mem_wdata = head_ff;
      mem_re    = 1'b0;
      mem_raddr = IDX_W'(head_ff);

      case (state_ff)
         fbpa_pkg::ST_IDLE: begin
            if (accept) begin
               case (fbpa_pkg::req_kind_type'(req_type))
                  fbpa_pkg::REQ_ALLOC: begin
                     // A size or alignment mismatch wins over an empty pool.
                     if (req_bytes != bytes_ff || req_align != pad_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = fbpa_pkg::STATUS_MISMATCH;
                     end else if (head_ff >= LIST_END) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = fbpa_pkg::STATUS_EMPTY;
                     end else begin
                        // Fetch the successor of the head block.
                        mem_re   = 1'b1;
                        state_in = fbpa_pkg::ST_POP;
                     end
                  end
                  fbpa_pkg::REQ_FREE: begin
                     rsp_strobe_in = 1'b1;
                     if (!req_free_is_null && freed_in_range) begin
                        // Push: the freed block links to the old head.
                        mem_we  = 1'b1;
                        head_in = LINK_W'(req_freed_block);
                        if (used_ff > fbpa_pkg::USED_W'(bytes_ff)) begin
                           used_in = used_ff - fbpa_pkg::USED_W'(bytes_ff);
                        end else begin
                           used_in = '0;
                        end
                        rsp_used_in = used_in;
                     end
                  end
                  fbpa_pkg::REQ_FREE_ALL: begin
                     build_n_in   = count_clamped;
                     build_cnt_in = '0;
                     build_rsp_in = 1'b1;
                     state_in     = fbpa_pkg::ST_BUILD;
                  end
                  fbpa_pkg::REQ_RESIZE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = fbpa_pkg::STATUS_RESIZE;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = fbpa_pkg::STATUS_RESIZE;
                  end
               endcase
            end
         end
         fbpa_pkg::ST_POP: begin
            // The link read issued at accept is now on mem_rdata.
            head_in = mem_rdata;
            if (used_sum > (fbpa_pkg::USED_W + 1)'(fbpa_pkg::USED_MAX)) begin
               used_in = fbpa_pkg::USED_MAX;
            end else begin
               used_in = fbpa_pkg::USED_W'(used_sum);
            end
            rsp_strobe_in = 1'b1;
            rsp_index_in  = fbpa_pkg::INDEX_W'(head_ff);
            rsp_offset_in = fbpa_pkg::OFFSET_W'(offset_product);
            rsp_used_in   = used_in;
            state_in      = fbpa_pkg::ST_IDLE;
         end
         fbpa_pkg::ST_BUILD: begin
            // Chain the blocks in ascending order, one link per cycle.
            mem_we    = 1'b1;
            mem_waddr = build_cnt_ff;
            mem_wdata = build_last ? LIST_END : LINK_W'(build_cnt_ff) + LINK_W'(1);
            build_cnt_in = build_cnt_ff + IDX_W'(1);
            if (build_last) begin
               build_cnt_in  = '0;
               head_in       = '0;
               used_in       = '0;
               rsp_strobe_in = build_rsp_ff;
               rsp_used_in   = '0;
               build_rsp_in  = 1'b0;
               state_in      = fbpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbpa_pkg::ST_IDLE;
         end
      endcase
   end

   // Register writes: software must write only while idle; the block does not check.
   always_comb begin
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      pad_in    = pad_ff;
      stride_in = stride_ff;
      if (csr_write) begin
         case (csr_index)
            fbpa_pkg::REG_BLOCK_COUNT: begin
               count_in = pwdata[fbpa_pkg::COUNT_W-1:0];
            end
            fbpa_pkg::REG_BLOCK_BYTES: begin
               bytes_in  = pwdata[fbpa_pkg::BYTES_W-1:0];
               stride_in = fbpa_pkg::STRIDE_W'(pwdata[fbpa_pkg::BYTES_W-1:0]) +
                           fbpa_pkg::STRIDE_W'(pad_ff);
            end
            fbpa_pkg::REG_BLOCK_PAD: begin
               pad_in    = pwdata[fbpa_pkg::PAD_W-1:0];
               stride_in = fbpa_pkg::STRIDE_W'(bytes_ff) +
                           fbpa_pkg::STRIDE_W'(pwdata[fbpa_pkg::PAD_W-1:0]);
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::CSR_DATA_W'(count_ff);
         fbpa_pkg::REG_BLOCK_BYTES: prdata = fbpa_pkg::CSR_DATA_W'(bytes_ff);
         fbpa_pkg::REG_BLOCK_PAD:   prdata = fbpa_pkg::CSR_DATA_W'(pad_ff);
         default:                   prdata = '0;
      endcase
   end

   // State register. Reset starts the chain build for the default block
   // count; that build produces no response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbpa_pkg::ST_BUILD;
         head_ff       <= '0;
         used_ff       <= '0;
         build_cnt_ff  <= '0;
         build_n_ff    <= LINK_W'(RESET_N);
         build_rsp_ff  <= 1'b0;
         count_ff      <= fbpa_pkg::RESET_COUNT;
         bytes_ff      <= fbpa_pkg::RESET_BYTES;
         pad_ff        <= fbpa_pkg::RESET_PAD;
         stride_ff     <= fbpa_pkg::STRIDE_W'(fbpa_pkg::RESET_BYTES) +
                          fbpa_pkg::STRIDE_W'(fbpa_pkg::RESET_PAD);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         used_ff       <= used_in;
         build_cnt_ff  <= build_cnt_in;
         build_n_ff    <= build_n_in;
         build_rsp_ff  <= build_rsp_in;
         count_ff      <= count_in;
         bytes_ff      <= bytes_in;
         pad_ff        <= pad_in;
         stride_ff     <= stride_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Response payload, qualified by the strobe.
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // A write to the link memory and a read of it never fall in the same
   // cycle: pushes happen at accept, reads at the next alloc's accept.
   assign busy            = (state_ff != fbpa_pkg::ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_byte_offset = rsp_offset_ff;
   assign rsp_used_bytes  = rsp_used_ff;
   assign pready          = 1'b1;

endmodule

>>> hdl/fbpa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; instantiated by fixed_block_pool_allocator for the link memory.
`timescale 1ns / 1ps

module fbpa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/fixed_block_pool_allocator_test.sv
// Self-checking bench for fixed_block_pool_allocator. It sends alloc, free, free-all and
// resize transactions and checks every response against a free-list predictor kept here.
// Depends on fbpa_pkg, fbpa_ram and the fixed_block_pool_allocator RTL only.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_test;

   // The bench runs the block with its default link memory size.
   localparam int POOL_SLOTS = fbpa_pkg::DEFAULT_MAX_BLOCKS;
   localparam logic [fbpa_pkg::COUNT_W-1:0] LIST_END = fbpa_pkg::COUNT_W'(POOL_SLOTS);
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      fbpa_pkg::req_kind_type              kind;
      logic [fbpa_pkg::INDEX_W-1:0]        freed;
      logic                                is_null;
      logic [fbpa_pkg::BYTES_W-1:0]        bytes;
      logic [fbpa_pkg::PAD_W-1:0]          align;
   } pool_request_type;

   typedef struct packed {
      fbpa_pkg::status_type                status;
      logic [fbpa_pkg::INDEX_W-1:0]        index;
      logic [fbpa_pkg::OFFSET_W-1:0]       offset;
      logic [fbpa_pkg::USED_W-1:0]         used;
   } pool_response_type;

   // Every input of the block starts at a known value.
   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [1:0]                          req_type = fbpa_pkg::REQ_ALLOC;
   logic [fbpa_pkg::INDEX_W-1:0]        req_freed_block = '0;
   logic                                req_free_is_null = 1'b0;
   logic [fbpa_pkg::BYTES_W-1:0]        req_bytes = '0;
   logic [fbpa_pkg::PAD_W-1:0]          req_align = '0;
   logic                                rsp_strobe;
   logic [1:0]                          rsp_status;
   logic [fbpa_pkg::INDEX_W-1:0]        rsp_block_index;
   logic [fbpa_pkg::OFFSET_W-1:0]       rsp_byte_offset;
   logic [fbpa_pkg::USED_W-1:0]         rsp_used_bytes;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [fbpa_pkg::CSR_ADDR_W-1:0]     paddr = '0;
   logic [fbpa_pkg::CSR_DATA_W-1:0]     pwdata = '0;
   logic [fbpa_pkg::CSR_DATA_W-1:0]     prdata;
   logic                                pready;

   // Stimulus side: requests waiting for the driver, and the register values that the
   // stimulus generator believes are programmed (used to build well-formed allocs).
   pool_request_type                    requests_to_send[$];
   int                                  requests_queued = 0;
   int                                  requests_accepted = 0;
   logic [fbpa_pkg::COUNT_W-1:0]        plan_count = fbpa_pkg::RESET_COUNT;
   logic [fbpa_pkg::BYTES_W-1:0]        plan_bytes = fbpa_pkg::RESET_BYTES;
   logic [fbpa_pkg::PAD_W-1:0]          plan_pad = fbpa_pkg::RESET_PAD;
   logic                                bursts_on = 1'b1;
   logic                                taken = 1'b0;
   int                                  gap_left = 0;

   // Predictor state: a private copy of the free list, the byte count and the registers.
   logic [fbpa_pkg::COUNT_W-1:0]        link_mem[POOL_SLOTS];
   logic [fbpa_pkg::COUNT_W-1:0]        list_head;
   logic [fbpa_pkg::USED_W-1:0]         used_total;
   logic [fbpa_pkg::COUNT_W-1:0]        cfg_count;
   logic [fbpa_pkg::BYTES_W-1:0]        cfg_bytes;
   logic [fbpa_pkg::PAD_W-1:0]          cfg_pad;
   pool_response_type                   responses_due[$];
   int                                  error_count = 0;
   int                                  cycle_count = 0;

   fixed_block_pool_allocator #(
      .MAX_BLOCKS(POOL_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_freed_block(req_freed_block),
      .req_free_is_null(req_free_is_null),
      .req_bytes(req_bytes),
      .req_align(req_align),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_block_index(rsp_block_index),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_used_bytes(rsp_used_bytes),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Relinks blocks 0 .. count-1 in ascending order. The programmed count is clamped to
   // 1 .. POOL_SLOTS; slots above the count keep whatever link they held before.
   function automatic void relink_pool();
      int n;
      int i;
      n = (cfg_count == 0) ? 1 : ((cfg_count > POOL_SLOTS) ? POOL_SLOTS : int'(cfg_count));
      for (i = 0; i < n; i++) begin
         link_mem[i] = (i + 1 < n) ? fbpa_pkg::COUNT_W'(i + 1) : LIST_END;
      end
      list_head = '0;
      used_total = '0;
   endfunction

   function automatic void reset_pool();
      int i;
      cfg_count = fbpa_pkg::RESET_COUNT;
      cfg_bytes = fbpa_pkg::RESET_BYTES;
      cfg_pad = fbpa_pkg::RESET_PAD;
      for (i = 0; i < POOL_SLOTS; i++) begin
         link_mem[i] = LIST_END;
      end
      relink_pool();
   endfunction

   // Applies one accepted transaction to the predicted pool and returns the response
   // that the block must produce for it.
   function automatic pool_response_type apply_pool_request(
         input fbpa_pkg::req_kind_type kind,
         input logic [fbpa_pkg::INDEX_W-1:0] freed,
         input logic is_null,
         input logic [fbpa_pkg::BYTES_W-1:0] bytes,
         input logic [fbpa_pkg::PAD_W-1:0] align);
      pool_response_type            resp;
      logic [31:0]                  stride;
      logic [fbpa_pkg::USED_W:0]    sum;
      resp = '0;
      case (kind)
         fbpa_pkg::REQ_ALLOC: begin
            // A size or alignment mismatch wins over an empty pool.
            if (bytes != cfg_bytes || align != cfg_pad) begin
               resp.status = fbpa_pkg::STATUS_MISMATCH;
            end else if (list_head >= LIST_END) begin
               resp.status = fbpa_pkg::STATUS_EMPTY;
            end else begin
               stride = 32'(cfg_bytes) + 32'(cfg_pad);
               resp.index = list_head[fbpa_pkg::INDEX_W-1:0];
               resp.offset = fbpa_pkg::OFFSET_W'(32'(list_head) * stride);
               list_head = link_mem[list_head[fbpa_pkg::INDEX_W-1:0]];
               sum = used_total;
               sum = sum + cfg_bytes;
               used_total = (sum > fbpa_pkg::USED_MAX) ? fbpa_pkg::USED_MAX :
                            sum[fbpa_pkg::USED_W-1:0];
            end
         end
         fbpa_pkg::REQ_FREE: begin
            // The freed index is trusted: a block that is already free, or one beyond the
            // programmed count, is pushed all the same. The byte count floors at zero.
            if (!is_null) begin
               link_mem[freed] = list_head;
               list_head = fbpa_pkg::COUNT_W'(freed);
               used_total = (used_total > cfg_bytes) ? used_total - cfg_bytes : '0;
            end
         end
         fbpa_pkg::REQ_FREE_ALL: begin
            relink_pool();
         end
         default: begin
            resp.status = fbpa_pkg::STATUS_RESIZE;
         end
      endcase
      resp.used = used_total;
      return resp;
   endfunction

   // Sampling side. Inputs only move at the falling edge, so everything seen here is
   // stable. Responses are checked before the transaction taken at this same edge is
   // predicted; a response never arrives at the edge that accepts its own request.
   always @(posedge clock) begin : check_pool
      pool_response_type want;
      if (reset) begin
         reset_pool();
         responses_due.delete();
         taken <= 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (responses_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: response with none outstanding: status %0d index %0d",
                           $time, rsp_status, rsp_block_index);
               end
            end else begin
               want = responses_due.pop_front();
               if (rsp_status !== want.status || rsp_block_index !== want.index ||
                   rsp_byte_offset !== want.offset || rsp_used_bytes !== want.used) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: expected status %0d index %0d offset %0d used %0d",
                              $time, want.status, want.index, want.offset, want.used);
                     $display("%0t:      got status %0d index %0d offset %0d used %0d",
                              $time, rsp_status, rsp_block_index, rsp_byte_offset,
                              rsp_used_bytes);
                  end
               end
            end
         end
         if (start && !busy) begin
            responses_due.push_back(apply_pool_request(
               fbpa_pkg::req_kind_type'(req_type), req_freed_block, req_free_is_null,
               req_bytes, req_align));
            requests_accepted++;
         end
         // Register writes land in the predictor at the same edge as in the block. A new
         // count only matters at the next free-all, which the predictor models as well.
         if (psel && penable && pwrite && pready) begin
            case (fbpa_pkg::reg_index_type'(paddr[3:2]))
               fbpa_pkg::REG_BLOCK_COUNT: cfg_count = pwdata[fbpa_pkg::COUNT_W-1:0];
               fbpa_pkg::REG_BLOCK_BYTES: cfg_bytes = pwdata[fbpa_pkg::BYTES_W-1:0];
               fbpa_pkg::REG_BLOCK_PAD:   cfg_pad = pwdata[fbpa_pkg::PAD_W-1:0];
               default: ;
            endcase
         end
         taken <= start && !busy;
      end
   end

   // Request driver. It holds start and the fields until the transaction is taken, then
   // either presents the next pending request at once or idles for a random burst.
   always @(negedge clock) begin : drive_requests
      pool_request_type item;
      logic             next_start;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (!start || taken) begin
         next_start = 1'b0;
         if (start && bursts_on && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 11);
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (requests_to_send.size() != 0) begin
            item = requests_to_send.pop_front();
            req_type <= item.kind;
            req_freed_block <= item.freed;
            req_free_is_null <= item.is_null;
            req_bytes <= item.bytes;
            req_align <= item.align;
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fixed_block_pool_allocator_test: done, errors");
         $finish;
      end
   end

   task automatic queue_request(input fbpa_pkg::req_kind_type kind,
                                input logic [fbpa_pkg::INDEX_W-1:0] freed,
                                input logic is_null,
                                input logic [fbpa_pkg::BYTES_W-1:0] bytes,
                                input logic [fbpa_pkg::PAD_W-1:0] align);
      pool_request_type item;
      item.kind = kind;
      item.freed = freed;
      item.is_null = is_null;
      item.bytes = bytes;
      item.align = align;
      requests_to_send.push_back(item);
      requests_queued++;
   endtask

   // A well-formed alloc with random content in the fields that alloc ignores.
   task automatic queue_alloc();
      queue_request(fbpa_pkg::REQ_ALLOC, fbpa_pkg::INDEX_W'($urandom), 1'($urandom),
                    plan_bytes, plan_pad);
   endtask

   task automatic queue_free(input logic [fbpa_pkg::INDEX_W-1:0] freed, input logic is_null);
      queue_request(fbpa_pkg::REQ_FREE, freed, is_null, fbpa_pkg::BYTES_W'($urandom),
                    fbpa_pkg::PAD_W'($urandom));
   endtask

   task automatic queue_free_all();
      queue_request(fbpa_pkg::REQ_FREE_ALL, fbpa_pkg::INDEX_W'($urandom), 1'($urandom),
                    fbpa_pkg::BYTES_W'($urandom), fbpa_pkg::PAD_W'($urandom));
   endtask

   // Register write over the APB-style port: setup cycle, then access cycle.
   task automatic write_register(input fbpa_pkg::reg_index_type index,
                                 input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         fbpa_pkg::REG_BLOCK_COUNT: plan_count = value[fbpa_pkg::COUNT_W-1:0];
         fbpa_pkg::REG_BLOCK_BYTES: plan_bytes = value[fbpa_pkg::BYTES_W-1:0];
         fbpa_pkg::REG_BLOCK_PAD:   plan_pad = value[fbpa_pkg::PAD_W-1:0];
         default: ;
      endcase
   endtask

   // Holds the sender off until every request has been taken, every response has come
   // back and the block has dropped busy (a free-all build may still be running).
   task automatic settle_pool();
      do @(negedge clock);
      while (requests_accepted != requests_queued || responses_due.size() != 0 ||
             busy !== 1'b0);
   endtask

   // Mostly well-formed allocs and frees of blocks inside the programmed count, with
   // some malformed allocs, stray frees, free-alls and resize requests mixed in.
   task automatic queue_mixed_requests(input int n);
      int pick;
      int live;
      live = (plan_count == 0) ? 1 :
             ((plan_count > POOL_SLOTS) ? POOL_SLOTS : int'(plan_count));
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            queue_alloc();
         end else if (pick < 55) begin
            queue_request(fbpa_pkg::REQ_ALLOC, fbpa_pkg::INDEX_W'($urandom), 1'($urandom),
                          fbpa_pkg::BYTES_W'($urandom), fbpa_pkg::PAD_W'($urandom));
         end else if (pick < 58) begin
            queue_request(fbpa_pkg::REQ_ALLOC, fbpa_pkg::INDEX_W'($urandom), 1'($urandom),
                          plan_bytes ^ fbpa_pkg::BYTES_W'(
                             1 << $urandom_range(0, fbpa_pkg::BYTES_W - 1)),
                          plan_pad);
         end else if (pick < 61) begin
            queue_request(fbpa_pkg::REQ_ALLOC, fbpa_pkg::INDEX_W'($urandom), 1'($urandom),
                          plan_bytes,
                          plan_pad ^ fbpa_pkg::PAD_W'(
                             1 << $urandom_range(0, fbpa_pkg::PAD_W - 1)));
         end else if (pick < 88) begin
            queue_free(($urandom_range(0, 3) == 0) ? fbpa_pkg::INDEX_W'($urandom) :
                       fbpa_pkg::INDEX_W'($urandom_range(0, live - 1)),
                       $urandom_range(0, 9) == 0);
         end else if (pick < 91) begin
            queue_free_all();
         end else begin
            queue_request(fbpa_pkg::REQ_RESIZE, fbpa_pkg::INDEX_W'($urandom), 1'($urandom),
                          fbpa_pkg::BYTES_W'($urandom), fbpa_pkg::PAD_W'($urandom));
         end
      end
   endtask

   initial begin : run_test
      int          phase;
      int          pick;
      logic [31:0] value;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Reset runs the free-all build; wait for it before sending anything.
      settle_pool();

      // Directed part on the reset registers: 256 blocks of 64 bytes plus 8 bytes pad.
      @(posedge clock);
      queue_alloc();
      queue_alloc();
      queue_request(fbpa_pkg::REQ_ALLOC, 8'hff, 1'b1, 16'hffff, plan_pad);
      queue_request(fbpa_pkg::REQ_ALLOC, 8'h00, 1'b0, plan_bytes, 13'h1fff);
      queue_request(fbpa_pkg::REQ_ALLOC, 8'h00, 1'b0, 16'h0000, 13'h0000);
      // A null free changes nothing; freeing a block that is still free is trusted.
      queue_free(8'hff, 1'b1);
      queue_free(8'hff, 1'b0);
      queue_alloc();
      queue_alloc();
      queue_request(fbpa_pkg::REQ_RESIZE, 8'hff, 1'b1, 16'hffff, 13'h1fff);
      queue_free(8'd0, 1'b0);
      queue_free(8'd1, 1'b0);
      queue_free(8'd2, 1'b0);
      // The byte count floors at zero, and a double free links block 0 to itself.
      queue_free(8'd0, 1'b0);
      queue_free(8'd0, 1'b0);
      queue_alloc();
      queue_free_all();
      queue_alloc();
      settle_pool();

      // One 65535-byte block with 4096 pad: a count of zero is taken as one. The pool runs
      // empty, a mismatch on an empty pool still reports mismatch, and a self-linked
      // block then allows enough allocs to push the byte count into saturation.
      write_register(fbpa_pkg::REG_BLOCK_COUNT, 32'd0);
      write_register(fbpa_pkg::REG_BLOCK_BYTES, 32'd65535);
      write_register(fbpa_pkg::REG_BLOCK_PAD, 32'd4096);
      @(posedge clock);
      queue_free_all();
      queue_alloc();
      queue_alloc();
      queue_request(fbpa_pkg::REQ_ALLOC, 8'd0, 1'b0, 16'd65534, plan_pad);
      queue_free(8'd0, 1'b0);
      queue_free(8'd0, 1'b0);
      repeat (258) queue_alloc();
      queue_free(8'd0, 1'b0);
      queue_alloc();
      settle_pool();

      // A count above the memory size is clamped; drain the full pool to reach the
      // largest offset and used byte count, then hit the empty pool.
      write_register(fbpa_pkg::REG_BLOCK_COUNT, 32'd300);
      @(posedge clock);
      queue_free_all();
      repeat (257) queue_alloc();
      settle_pool();

      // Random phases, each with fresh registers and a free-all to apply the count.
      // One phase in the middle and the last one run without sender idling.
      for (phase = 0; phase < 10; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) value = $urandom_range(1, 16);
         else if (pick == 6) value = 0;
         else if (pick == 7) value = $urandom_range(257, 511);
         else if (pick == 8) value = $urandom_range(1, 256);
         else value = 2;
         write_register(fbpa_pkg::REG_BLOCK_COUNT, value);
         pick = $urandom_range(0, 3);
         value = (pick == 0) ? 1 : ((pick == 1) ? 65535 : $urandom_range(1, 512));
         write_register(fbpa_pkg::REG_BLOCK_BYTES, value);
         pick = $urandom_range(0, 3);
         value = (pick == 0) ? 0 : ((pick == 1) ? 4096 : $urandom_range(0, 64));
         write_register(fbpa_pkg::REG_BLOCK_PAD, value);
         @(posedge clock);
         bursts_on = (phase != 4 && phase != 9);
         queue_free_all();
         queue_mixed_requests(25);
         settle_pool();
      end

      // Quiet tail: any response showing up now has no request behind it.
      repeat (16) @(negedge clock);
      if (error_count == 0 && responses_due.size() == 0) begin
         $display("fixed_block_pool_allocator_test: done, clean");
      end else begin
         $display("fixed_block_pool_allocator_test: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/fbpa_pkg.sv
hdl/fbpa_ram.sv
hdl/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_test.sv
